/* design/counting_bloom_counter_table_assert.svh */
// assertion macros for the counting bloom counter table
`ifndef COUNTING_BLOOM_COUNTER_TABLE_ASSERT_SVH
`define COUNTING_BLOOM_COUNTER_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CBCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CBCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cbct_pkg.sv */
// shared types and constants of the counting bloom counter table
package cbct_pkg;

   localparam int NUM_COUNTERS = 1024;
   localparam int MAX_HASHES   = 8;

   localparam int IDX_W      = 10;
   localparam int NUM_FIELDS = 8;
   localparam int ADDR_W     = $clog2(NUM_COUNTERS);
   localparam int CNT_W      = 8;
   localparam int CIU_W      = 11;
   localparam int HASH_W     = 4;
   localparam int STEP_W     = $clog2(MAX_HASHES + 1);
   localparam int SEL_W      = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
   localparam int TOTAL_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REQ_DATA_W = NUM_FIELDS * IDX_W;
   localparam int RSP_DATA_W = 48;

   localparam logic [CNT_W-1:0] NIBBLE_MASK = 8'b00001111;
   localparam logic [CNT_W-1:0] HIGH_MASK   = 8'b11110000;
   localparam logic [CNT_W-1:0] NARROW_TOP  = 8'd15;
   localparam logic [CNT_W-1:0] WIDE_TOP    = 8'd255;

   localparam logic [CIU_W-1:0]  CIU_RESET    = 11'd1024;
   localparam logic [HASH_W-1:0] HASHES_RESET = 4'd4;

   typedef enum logic [1:0] {
      KIND_QUERY  = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_UNDER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DELTA_NONE = 2'd0,
      DELTA_UP   = 2'd1,
      DELTA_DOWN = 2'd2
   } delta_type;

   typedef enum logic {
      ENTRY_REPORT  = 1'b0,
      ENTRY_SUMMARY = 1'b1
   } entry_type;

   typedef enum logic [1:0] {
      REG_COUNTERS = 2'd0,
      REG_HASHES   = 2'd1,
      REG_NARROW   = 2'd2
   } reg_type;

   typedef enum logic [2:0] {
      S_CLEAR    = 3'd0,
      S_IDLE     = 3'd1,
      S_MEM_ADDR = 3'd2,
      S_MEM_DATA = 3'd3,
      S_UPD_ADDR = 3'd4,
      S_UPD_DATA = 3'd5,
      S_SUMMARY  = 3'd6
   } state_type;

   // effective configuration, already saturated
   typedef struct packed {
      logic [CIU_W-1:0]  lim;
      logic [STEP_W-1:0] n;
      logic              narrow;
   } cfg_type;

   typedef struct packed {
      logic       clr_wr;
      logic       load;
      logic       step_rst;
      logic       step_inc;
      logic       rd;
      logic       wr;
      logic       emit_rpt;
      logic       emit_sum;
      logic       clr_member;
      logic       status_wr;
      status_type status;
      logic       delta_wr;
      delta_type  delta;
   } cmd_type;

   typedef struct packed {
      logic     clear_last;
      logic     at_end;
      logic     idx_bad;
      logic     cnt_zero;
      logic     cnt_one;
      logic     cnt_top;
      logic     out_free;
      kind_type kind;
   } sts_type;

endpackage

/* design/cbct_csr.sv */
// configuration registers and their bus port
module cbct_csr import cbct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CIU_W-1:0]  ciu_ff, ciu_in;
   logic [HASH_W-1:0] hashes_ff, hashes_in;
   logic              narrow_ff, narrow_in;
   logic              wr_en;
   reg_type           reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_type'(csr_paddr[3:2]);

   always_comb begin
      ciu_in    = ciu_ff;
      hashes_in = hashes_ff;
      narrow_in = narrow_ff;
      csr_prdata = '0;
      unique case (reg_sel)
         REG_COUNTERS: begin
            csr_prdata = CSR_DATA_W'(ciu_ff);
            if (wr_en) ciu_in = csr_pwdata[CIU_W-1:0];
         end
         REG_HASHES: begin
            csr_prdata = CSR_DATA_W'(hashes_ff);
            if (wr_en) hashes_in = csr_pwdata[HASH_W-1:0];
         end
         REG_NARROW: begin
            csr_prdata = CSR_DATA_W'(narrow_ff);
            if (wr_en) narrow_in = csr_pwdata[0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ciu_ff    <= CIU_RESET;
         hashes_ff <= HASHES_RESET;
         narrow_ff <= 1'b0;
      end else begin
         ciu_ff    <= ciu_in;
         hashes_ff <= hashes_in;
         narrow_ff <= narrow_in;
      end
   end

   // saturate the in-use counts
   always_comb begin
      cfg.lim    = (int'(ciu_ff) > NUM_COUNTERS) ? CIU_W'(NUM_COUNTERS) : ciu_ff;
      cfg.n      = (int'(hashes_ff) > MAX_HASHES) ? STEP_W'(MAX_HASHES)
                                                   : STEP_W'(hashes_ff);
      cfg.narrow = narrow_ff;
   end

endmodule

/* design/cbct_ctrl.sv */
// controller state machine: clearing, membership pass, update pass, summary
module cbct_ctrl import cbct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      is_add, is_rem;

   assign is_add = (sts.kind == KIND_ADD);
   assign is_rem = (sts.kind == KIND_REMOVE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load     = 1'b1;
               cmd.step_rst = 1'b1;
               state_in     = S_MEM_ADDR;
            end
         end
         S_MEM_ADDR: begin
            if (sts.at_end) begin
               cmd.step_rst = 1'b1;
               state_in     = (is_add || is_rem) ? S_UPD_ADDR : S_SUMMARY;
            end else if (sts.idx_bad) begin
               cmd.clr_member = 1'b1;
               if (is_add) begin
                  cmd.step_rst = 1'b1;
                  state_in     = S_UPD_ADDR;
               end else begin
                  cmd.status_wr = 1'b1;
                  cmd.status    = STAT_RANGE;
                  state_in      = S_SUMMARY;
               end
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_MEM_DATA;
            end
         end
         S_MEM_DATA: begin
            if (sts.cnt_zero) begin
               cmd.clr_member = 1'b1;
               if (is_add) begin
                  cmd.step_rst = 1'b1;
                  state_in     = S_UPD_ADDR;
               end else begin
                  if (is_rem) begin
                     cmd.delta_wr = 1'b1;
                     cmd.delta    = DELTA_DOWN;
                  end
                  state_in = S_SUMMARY;
               end
            end else begin
               cmd.step_inc = 1'b1;
               state_in     = S_MEM_ADDR;
            end
         end
         S_UPD_ADDR: begin
            if (sts.at_end) begin
               cmd.delta_wr = 1'b1;
               cmd.delta    = is_add ? DELTA_UP : DELTA_DOWN;
               state_in     = S_SUMMARY;
            end else if (sts.idx_bad) begin
               cmd.status_wr = 1'b1;
               cmd.status    = STAT_RANGE;
               state_in      = S_SUMMARY;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_UPD_DATA;
            end
         end
         S_UPD_DATA: begin
            if (is_add) begin
               if (sts.cnt_top) begin
                  cmd.status_wr = 1'b1;
                  cmd.status    = STAT_OVER;
                  state_in      = S_SUMMARY;
               end else if (!sts.cnt_zero || sts.out_free) begin
                  cmd.wr       = 1'b1;
                  cmd.emit_rpt = sts.cnt_zero;
                  cmd.step_inc = 1'b1;
                  state_in     = S_UPD_ADDR;
               end
            end else begin
               if (sts.cnt_zero) begin
                  cmd.status_wr = 1'b1;
                  cmd.status    = STAT_UNDER;
                  state_in      = S_SUMMARY;
               end else if (!sts.cnt_one || sts.out_free) begin
                  cmd.wr       = 1'b1;
                  cmd.emit_rpt = sts.cnt_one;
                  cmd.step_inc = 1'b1;
                  state_in     = S_UPD_ADDR;
               end
            end
         end
         S_SUMMARY: begin
            if (sts.out_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* design/cbct_dp.sv */
// datapath: item registers, counter memory, element count, result register
`include "counting_bloom_counter_table_assert.svh"

module cbct_dp import cbct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  cfg_type               cfg,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [CNT_W-1:0]   mem [NUM_COUNTERS];

   kind_type           kind_ff;
   logic [IDX_W-1:0]   index_ff [MAX_HASHES];
   logic [STEP_W-1:0]  step_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [CNT_W-1:0]   rd_data_ff;
   logic               member_ff;
   status_type         status_ff;
   delta_type          delta_ff;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff;
   entry_type          rsp_kind_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic               rsp_rose_ff;
   logic               rsp_member_ff;
   status_type         rsp_status_ff;
   logic [TOTAL_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   logic [IDX_W-1:0]   idx_cur;
   logic [ADDR_W-1:0]  addr_cur;
   logic [CNT_W-1:0]   cnt, top, wr_value;
   logic               is_add;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CNT_W-1:0]   mem_wdata;

   assign idx_cur  = index_ff[step_ff[SEL_W-1:0]];
   assign addr_cur = ADDR_W'(idx_cur);
   assign is_add   = (kind_ff == KIND_ADD);

   // narrow mode sees only the low nibble
   assign cnt      = cfg.narrow ? (rd_data_ff & NIBBLE_MASK) : rd_data_ff;
   assign top      = cfg.narrow ? NARROW_TOP : WIDE_TOP;
   assign wr_value = is_add ? cnt + CNT_W'(1) : cnt - CNT_W'(1);

   assign mem_we    = cmd.clr_wr | cmd.wr;
   assign mem_waddr = cmd.clr_wr ? clr_addr_ff : addr_cur;
   assign mem_wdata = cmd.clr_wr ? '0 : wr_value;

   always_comb begin
      sts.clear_last = (clr_addr_ff == ADDR_W'(NUM_COUNTERS - 1));
      sts.at_end     = (step_ff == cfg.n);
      sts.idx_bad    = (CIU_W'(idx_cur) >= cfg.lim);
      sts.cnt_zero   = (cnt == '0);
      sts.cnt_one    = (cnt == CNT_W'(1));
      sts.cnt_top    = (cnt >= top);
      sts.out_free   = !rsp_valid_ff || rsp_tready;
      sts.kind       = kind_ff;
   end

   always_comb begin
      case (delta_ff)
         DELTA_UP:   total_in = total_ff + TOTAL_W'(1);
         DELTA_DOWN: total_in = total_ff - TOTAL_W'(1);
         default:    total_in = total_ff;
      endcase
   end

   // counter memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.rd) rd_data_ff <= mem[addr_cur];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_tuser);
         for (int k = 0; k < MAX_HASHES; k++) begin
            index_ff[k] <= req_tdata[k*IDX_W +: IDX_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         clr_addr_ff <= '0;
         member_ff   <= 1'b1;
         status_ff   <= STAT_OK;
         delta_ff    <= DELTA_NONE;
         total_ff    <= '0;
      end else begin
         if (cmd.clr_wr)        clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (cmd.step_rst)      step_ff <= '0;
         else if (cmd.step_inc) step_ff <= step_ff + STEP_W'(1);
         if (cmd.load) begin
            member_ff <= 1'b1;
            status_ff <= STAT_OK;
            delta_ff  <= DELTA_NONE;
         end else begin
            if (cmd.clr_member) member_ff <= 1'b0;
            if (cmd.status_wr)  status_ff <= cmd.status;
            if (cmd.delta_wr)   delta_ff  <= cmd.delta;
         end
         if (cmd.emit_sum) total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_rpt || cmd.emit_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_rpt) begin
         rsp_kind_ff   <= ENTRY_REPORT;
         rsp_index_ff  <= idx_cur;
         rsp_rose_ff   <= is_add;
         rsp_member_ff <= 1'b0;
         rsp_status_ff <= STAT_OK;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_sum) begin
         rsp_kind_ff   <= ENTRY_SUMMARY;
         rsp_index_ff  <= '0;
         rsp_rose_ff   <= 1'b0;
         rsp_member_ff <= member_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= total_in;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_status_ff, rsp_member_ff,
                        rsp_rose_ff, rsp_index_ff};

   `CBCT_ASSERT_NOW(a_emit_has_room, cmd.emit_rpt || cmd.emit_sum, !rsp_valid_ff || rsp_tready, "result emitted over a waiting beat")
   `CBCT_ASSERT_NOW(a_report_with_write, cmd.emit_rpt, cmd.wr && !cmd.emit_sum, "report without its counter write")
   `CBCT_ASSERT_NEXT(a_summary_is_last, cmd.emit_sum, rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == ENTRY_SUMMARY), "summary beat not marked last")
   `CBCT_ASSERT_NOW(a_clear_exclusive, cmd.clr_wr, !cmd.rd && !cmd.wr && !cmd.load, "memory access during clearing pass")

endmodule

/* design/counting_bloom_counter_table.sv */
// Counter table of a counting bloom filter. Each request beat carries a kind in
// req_tuser (query, add, remove; the spare code acts as a query) and eight
// precomputed 10-bit hash indices in req_tdata, of which the first
// hashes_in_use are used. The block first walks the used indices to find
// membership, then for an add, or for a remove of a member, walks them again
// with a read-modify-write of each 8-bit counter (4-bit when narrow_counters
// is set). Every counter that rises to 1 or falls to 0 gives one report beat,
// and every item ends with a summary beat (rsp_tlast high) holding membership,
// status and the running element count. Each counter access takes an address
// state and a data state, as the counter memory has a registered read; an item
// can also wait on rsp_tready. After reset a clearing pass zeroes the 1024
// counters, one a cycle, before the first request beat is taken;
// configuration writes are accepted throughout. Registers (APB-style port):
// 0x0 counters_in_use, 0x4 hashes_in_use, 0x8 narrow_counters.
module counting_bloom_counter_table import cbct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // index_0 .. index_7, 10 bits each
   input  logic [1:0]            req_tuser,  // kind
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // counter_index, rose, member, status,
                                             // element_count, 2 zero bits
   output logic                  rsp_tuser,  // entry_kind
   output logic                  rsp_tlast,  // last
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;  // saturated register values
   cmd_type cmd;  // controller to datapath
   sts_type sts;  // datapath to controller

   // registers
   cbct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer for clearing, membership and update passes
   cbct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // counter memory, item registers and result register
   cbct_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
